// File: rtl/brsm_pkg.sv
// Package for the bucketed read-success monitor.
// Holds the shared constants, the command code and the input word type.
// No dependencies.
package brsm_pkg;

  // Default number of bucket periods in the window.
  localparam int unsigned BUCKET_COUNT_DEF = 60;

  // Field widths fixed by the interface.
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned TPM_W   = 24;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned OUT_W   = 22;

  // Period register: reset value and the smallest period that is honoured.
  localparam logic [TPM_W-1:0] TPM_RESET = 24'd1966080;
  localparam logic [TPM_W-1:0] TPM_MIN   = 24'd65536;

  // A bucket attempt counter stops at this value.
  localparam logic [CNT_W-1:0] BUCKET_MAX = 16'hFFFF;

  // Reported window totals saturate at this value.
  localparam logic [OUT_W-1:0] OUT_MAX = 22'h3FFFFF;

  // Command carried by an input word.
  typedef enum logic {
    CMD_ATTEMPT = 1'b0,
    CMD_TIME    = 1'b1
  } cmd_t;

  // One input word.
  typedef struct packed {
    cmd_t               cmd;
    logic               successful;
    logic [TICKS_W-1:0] elapsed_ticks;
  } item_t;

endpackage

// File: rtl/brsm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the bucket counter store. No dependencies.
module brsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; a read at the address being written returns the old data.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/brsm_core.sv
// Bucket update engine of the read-success monitor.
// Reads, modifies and writes back the bucket RAM, keeps the window totals.
// Depends on brsm_pkg; drives the ports of a brsm_ram instance.
module brsm_core
  import brsm_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF,
  parameter int unsigned IDX_W        = $clog2(BUCKET_COUNT),
  parameter int unsigned TOT_W        = $clog2(BUCKET_COUNT * 65535 + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  // Period register write.
  input  logic               cfg_wr_en,
  input  logic [TPM_W-1:0]   cfg_wr_data,
  // Input words.
  input  logic               item_valid,
  input  item_t              item,
  output logic               item_stall,
  // Results towards the output register.
  input  logic               res_ready,
  output logic               res_valid,
  output logic               res_full,
  output logic [TOT_W-1:0]   res_successes,
  output logic [TOT_W-1:0]   res_attempts,
  // Bucket RAM port: {successes, attempts}.
  output logic               ram_wr_en,
  output logic [IDX_W-1:0]   ram_wr_addr,
  output logic [2*CNT_W-1:0] ram_wr_data,
  output logic [IDX_W-1:0]   ram_rd_addr,
  input  logic [2*CNT_W-1:0] ram_rd_data
);

  localparam int unsigned MIN_W = $clog2(BUCKET_COUNT + 1);
  localparam int unsigned ACC_W = TPM_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_COUNT - 1);
  localparam logic [MIN_W-1:0] MIN_FULL = MIN_W'(BUCKET_COUNT);

  // Ring increment of a bucket index.
  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
    ring_inc = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  endfunction

  // Architectural state.
  logic [TPM_W-1:0]        period_r;
  logic [IDX_W-1:0]        cur_r, cur_nxt;
  logic [MIN_W-1:0]        min_r, min_nxt;
  logic [ACC_W-1:0]        acc_r;
  logic [TOT_W-1:0]        tot_s_r, tot_s_nxt;
  logic [TOT_W-1:0]        tot_a_r, tot_a_nxt;
  logic [BUCKET_COUNT-1:0] vld_r;

  // Word being worked on.
  logic               b_valid_r;
  cmd_t               b_cmd_r;
  logic               b_ok_r;
  logic [TICKS_W-1:0] b_ticks_r;
  logic               b_first_r;

  // Read side: valid bit and forwarded write captured with the RAM read.
  logic               rd_vld_r;
  logic               fwd_hit_r, fwd_hit_nxt;
  logic [2*CNT_W-1:0] fwd_data_r, fwd_data_nxt;

  logic [2*CNT_W-1:0] bkt;
  logic [CNT_W-1:0]   bkt_s, bkt_a;
  logic [ACC_W-1:0]   acc_work;
  logic               is_time, adv, b_done, accept, att_full, wr_en;
  logic [IDX_W-1:0]   cur_inc, rd_addr;
  cmd_t               cmd_next;

  // Bucket contents as seen by the current word: forwarded write first,
  // then the RAM, and an entry not written since reset or expiry reads as zero.
  assign bkt   = fwd_hit_r ? fwd_data_r : (rd_vld_r ? ram_rd_data : '0);
  assign bkt_s = bkt[2*CNT_W-1:CNT_W];
  assign bkt_a = bkt[CNT_W-1:0];

  // Time words: add the ticks on the first cycle, then work off whole periods.
  assign is_time  = (b_cmd_r == CMD_TIME);
  assign acc_work = b_first_r ? acc_r + ACC_W'(b_ticks_r) : acc_r;
  assign adv      = b_valid_r && is_time && (acc_work >= ACC_W'(period_r));

  // Completion and acceptance.
  assign b_done     = b_valid_r && res_ready && !adv;
  assign accept     = item_valid && (!b_valid_r || b_done);
  assign item_stall = b_valid_r && !b_done;

  // Attempt write-back, skipped when the bucket has saturated.
  assign att_full    = (bkt_a == BUCKET_MAX);
  assign wr_en       = b_done && !is_time && !att_full;
  assign ram_wr_en   = wr_en;
  assign ram_wr_addr = cur_r;
  assign ram_wr_data = {bkt_s + CNT_W'(b_ok_r), bkt_a + CNT_W'(1)};

  // Ring position after this cycle and the entry the next cycle needs.
  assign cur_inc     = ring_inc(cur_r);
  assign cur_nxt     = adv ? cur_inc : cur_r;
  assign cmd_next    = accept ? item.cmd : b_cmd_r;
  assign rd_addr     = (cmd_next == CMD_TIME) ? ring_inc(cur_nxt) : cur_nxt;
  assign ram_rd_addr = rd_addr;

  // Forward a write or an expiry that lands on the entry being read.
  always_comb begin
    fwd_hit_nxt  = (wr_en && (rd_addr == cur_r)) || (adv && (rd_addr == cur_inc));
    fwd_data_nxt = wr_en ? ram_wr_data : '0;
  end

  // Window totals and elapsed periods.
  always_comb begin
    tot_s_nxt = tot_s_r;
    tot_a_nxt = tot_a_r;
    min_nxt   = min_r;
    if (adv) begin
      tot_s_nxt = tot_s_r - TOT_W'(bkt_s);
      tot_a_nxt = tot_a_r - TOT_W'(bkt_a);
      if (min_r != MIN_FULL) begin
        min_nxt = min_r + MIN_W'(1);
      end
    end else if (wr_en) begin
      tot_s_nxt = tot_s_r + TOT_W'(b_ok_r);
      tot_a_nxt = tot_a_r + TOT_W'(1);
    end
  end

  // Result for the output register.
  assign res_valid     = b_done;
  assign res_full      = (min_nxt == MIN_FULL);
  assign res_successes = tot_s_nxt;
  assign res_attempts  = tot_a_nxt;

  // Control state and totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= TPM_RESET;
      cur_r     <= '0;
      min_r     <= '0;
      acc_r     <= '0;
      tot_s_r   <= '0;
      tot_a_r   <= '0;
      vld_r     <= '0;
      b_valid_r <= 1'b0;
      b_first_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= (cfg_wr_data < TPM_MIN) ? TPM_MIN : cfg_wr_data;
      end
      cur_r   <= cur_nxt;
      min_r   <= min_nxt;
      tot_s_r <= tot_s_nxt;
      tot_a_r <= tot_a_nxt;
      if (b_valid_r && is_time) begin
        acc_r <= adv ? acc_work - ACC_W'(period_r) : acc_work;
      end
      if (wr_en) begin
        vld_r[cur_r] <= 1'b1;
      end else if (adv) begin
        vld_r[cur_inc] <= 1'b0;
      end
      if (accept) begin
        b_valid_r <= 1'b1;
        b_first_r <= 1'b1;
      end else begin
        if (b_done) begin
          b_valid_r <= 1'b0;
        end
        if (b_valid_r && is_time) begin
          b_first_r <= 1'b0;
        end
      end
    end
  end

  // Word registers and read-side capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      b_cmd_r   <= item.cmd;
      b_ok_r    <= item.successful;
      b_ticks_r <= item.elapsed_ticks;
    end
    rd_vld_r   <= vld_r[rd_addr];
    fwd_hit_r  <= fwd_hit_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

  // Successes can never outnumber attempts in the window.
  a_tot_order: assert property (@(posedge clk) disable iff (!rst_n)
    tot_s_r <= tot_a_r)
    else $error("window successes exceed window attempts");

  // Between time words the accumulator holds less than one full period range.
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    !(b_valid_r && is_time) |-> (acc_r[ACC_W-1] == 1'b0))
    else $error("tick accumulator overflowed between time words");

  // The ring index stays inside the ring.
  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= LAST_IDX)
    else $error("bucket index out of range");

  // An expiry always moves the ring on by one entry.
  a_adv_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (cur_r == ring_inc($past(cur_r))))
    else $error("bucket index did not advance on expiry");

endmodule

// File: rtl/brsm_out.sv
// Output register of the read-success monitor with the degradation decision.
// Saturates the reported totals to the port width. Depends on brsm_pkg.
module brsm_out
  import brsm_pkg::*;
#(
  parameter int unsigned TOT_W = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  // From the update engine.
  input  logic             res_valid,
  input  logic             res_full,
  input  logic [TOT_W-1:0] res_successes,
  input  logic [TOT_W-1:0] res_attempts,
  output logic             res_ready,
  // Result channel.
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_degraded,
  output logic             out_window_full,
  output logic [OUT_W-1:0] out_window_successes,
  output logic [OUT_W-1:0] out_window_attempts
);

  localparam int unsigned EXT_W = (TOT_W > OUT_W) ? TOT_W : OUT_W;
  localparam int unsigned MUL_W = TOT_W + 4;

  logic             valid_r;
  logic             full_r;
  logic [TOT_W-1:0] succ_r, att_r;
  logic [EXT_W-1:0] succ_ext, att_ext;
  logic [MUL_W-1:0] succ_x10, att_x9;

  assign res_ready = !valid_r || !out_stall;

  // Output word register; it is refilled whenever the current word leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      full_r <= res_full;
      succ_r <= res_successes;
      att_r  <= res_attempts;
    end
  end

  // Degraded when the ratio falls under nine in ten on a full, non-empty window.
  assign succ_x10 = (MUL_W'(succ_r) << 3) + (MUL_W'(succ_r) << 1);
  assign att_x9   = (MUL_W'(att_r) << 3) + MUL_W'(att_r);

  // Totals clipped to the port width.
  assign succ_ext = EXT_W'(succ_r);
  assign att_ext  = EXT_W'(att_r);

  assign out_valid            = valid_r;
  assign out_window_full      = full_r;
  assign out_degraded         = full_r && (att_r != '0) && (succ_x10 < att_x9);
  assign out_window_successes = (succ_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : succ_ext[OUT_W-1:0];
  assign out_window_attempts  = (att_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : att_ext[OUT_W-1:0];

endmodule

// File: rtl/bucketed_read_success_monitor_top.sv
// Bucketed read-success monitor, top level.
// Each accepted word is registered; the next is accepted as it completes.
// Attempt words and time words that close no period complete unless the output stalls;
// a time word first does one RAM read for each bucket period it closes.
// Reset is synchronous: bucket valid bits, totals and counters clear together, with no sweep.
// Depends on brsm_pkg, brsm_core, brsm_ram and brsm_out.
module bucketed_read_success_monitor_top
  import brsm_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration.
  input  logic               cfg_wr_en,
  input  logic [TPM_W-1:0]   cfg_wr_data,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic               in_successful,
  input  logic [TICKS_W-1:0] in_elapsed_ticks,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_degraded,
  output logic               out_window_full,
  output logic [OUT_W-1:0]   out_window_successes,
  output logic [OUT_W-1:0]   out_window_attempts
);

  localparam int unsigned IDX_W = $clog2(BUCKET_COUNT);
  localparam int unsigned TOT_W = $clog2(BUCKET_COUNT * 65535 + 1);

  item_t              item;
  logic               res_valid, res_ready, res_full;
  logic [TOT_W-1:0]   res_successes, res_attempts;
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
  logic [2*CNT_W-1:0] ram_wr_data, ram_rd_data;

  // Gather the input word.
  always_comb begin
    item.cmd           = cmd_t'(in_cmd);
    item.successful    = in_successful;
    item.elapsed_ticks = in_elapsed_ticks;
  end

  // Update engine.
  brsm_core #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .IDX_W       (IDX_W),
    .TOT_W       (TOT_W)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item_valid   (in_valid),
    .item         (item),
    .item_stall   (in_stall),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .res_full     (res_full),
    .res_successes(res_successes),
    .res_attempts (res_attempts),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data)
  );

  // Bucket store: successes in the upper half, attempts in the lower half.
  brsm_ram #(
    .WIDTH(2 * CNT_W),
    .DEPTH(BUCKET_COUNT)
  ) u_bucket_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Output register and decision.
  brsm_out #(
    .TOT_W(TOT_W)
  ) u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .res_valid           (res_valid),
    .res_full            (res_full),
    .res_successes       (res_successes),
    .res_attempts        (res_attempts),
    .res_ready           (res_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_degraded        (out_degraded),
    .out_window_full     (out_window_full),
    .out_window_successes(out_window_successes),
    .out_window_attempts (out_window_attempts)
  );

endmodule
